// ===== design/gvl_pkg.sv =====
// Package: widths, reset values and codes for the gated velocity low-pass.
`timescale 1ns / 1ps
`default_nettype none
package gvl_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [30:0] MAXH_RST = 31'd327680;
    localparam logic [30:0] MAXV_RST = 31'd196608;
    localparam logic [33:0] TAU_RST = 34'd200000000;
    localparam logic [1:0] QUALITY_GOOD = 2'd2;
    localparam logic [63:0] NS_PER_S = 64'd1000000000;
    localparam logic [62:0] DT_MIN_NS = 63'd5000000;
    localparam logic [62:0] DT_MAX_NS = 63'd200000000;
    localparam logic [1:0] REG_MAXH = 2'd0;
    localparam logic [1:0] REG_MAXV = 2'd1;
    localparam logic [1:0] REG_TAUH = 2'd2;
    localparam logic [1:0] REG_TAUV = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_GATE  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_LPDIV = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ===== design/gated_velocity_lowpass.sv =====
// Top level: gated finite-difference velocity with first-order low-pass.
//
// channel  dir  handshake          word
// s_       in   tvalid/tready      pos x,y,z, frame_time, quality, map count
// m_       out  tvalid/tready      vel x,y,z, valid
// apb      in   psel/penable       four registers at 8*i
//
// A filtered item passes one gate state, then multiply, divide and check for
// each of the three axes for the raw speed, then multiply, divide and filter
// update for each axis, and one output state, on one bit-serial shift-add
// multiplier and one restoring divider. A seeding or speed-rejected item skips
// the filter steps; a gate-rejected item goes from the gate to the output.
// Reset clears the tracker and loads the register defaults.
// s_tready is low while an item is at work or its result waits on m_.
`timescale 1ns / 1ps
`default_nettype none
module gated_velocity_lowpass #(
    parameter int FRAC_BITS = gvl_pkg::FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], frame_time[158:96],
    // pose_quality[160:159], map_reset_count[176:161], zero fill to 184
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // vel_x[31:0], vel_y[63:32], vel_z[95:64]
    output logic [95:0]       m_tdata,
    // vel_valid[0]
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    localparam logic [30:0] MAXH_RST_P = 31'(64'd5 << FRAC_BITS);
    localparam logic [30:0] MAXV_RST_P = 31'(64'd3 << FRAC_BITS);

    gvl_pkg::state_t state_reg;
    logic [30:0] maxh_reg, maxv_reg;
    logic [33:0] tauh_reg, tauv_reg;
    logic [31:0] px_reg [3];
    logic [62:0] ptime_reg;
    logic [1:0]  pq_reg;
    logic [15:0] pc_reg;
    logic        have_prev_reg, have_filt_reg;
    logic [31:0] filt_reg [3];
    logic [31:0] raw_reg [3];
    logic [31:0] cx_reg [3];
    logic [62:0] ct_reg;
    logic [1:0]  cq_reg;
    logic [15:0] cc_reg;
    logic [62:0] dt_reg;
    logic [1:0]  axis_reg;
    logic        lp_reg, neg_reg, ok_reg;
    logic [63:0] mcand_reg, mplier_reg, acc_reg;
    logic [63:0] den_reg, quo_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] out_data_reg;
    logic        out_valid_reg, out_user_reg;

    logic        wr_en;
    logic [1:0]  wr_idx;
    logic [32:0] diff;
    logic [32:0] dfl;
    logic [63:0] rem_sh, rem_sub;
    logic [33:0] tau_sel;
    logic [31:0] mag_sel;
    logic [32:0] lim;
    logic [31:0] qsat;
    logic [31:0] newf;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign wr_idx = paddr[4:3];
    assign s_tready = (state_reg == gvl_pkg::ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    always_comb begin
        case (wr_idx)
            gvl_pkg::REG_MAXH: prdata = {33'd0, maxh_reg};
            gvl_pkg::REG_MAXV: prdata = {33'd0, maxv_reg};
            gvl_pkg::REG_TAUH: prdata = {30'd0, tauh_reg};
            gvl_pkg::REG_TAUV: prdata = {30'd0, tauv_reg};
            default: prdata = 64'd0;
        endcase
    end

    always_comb begin
        diff = {cx_reg[axis_reg][31], cx_reg[axis_reg]} - {px_reg[axis_reg][31], px_reg[axis_reg]};
        dfl = {raw_reg[axis_reg][31], raw_reg[axis_reg]}
            - {filt_reg[axis_reg][31], filt_reg[axis_reg]};
        tau_sel = (axis_reg == 2'd2) ? tauv_reg : tauh_reg;
        lim = (axis_reg == 2'd2) ? {2'b0, maxv_reg} : {2'b0, maxh_reg};
        rem_sh = {rem_reg[62:0], quo_reg[63]};
        rem_sub = rem_sh - den_reg;
        qsat = (quo_reg > 64'h7FFF_FFFF) ? (neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                          : quo_reg[31:0];
        mag_sel = neg_reg ? (32'd0 - qsat) : qsat;
        newf = neg_reg ? (filt_reg[axis_reg] - quo_reg[31:0])
                       : (filt_reg[axis_reg] + quo_reg[31:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gvl_pkg::ST_IDLE;
            maxh_reg <= MAXH_RST_P;
            maxv_reg <= MAXV_RST_P;
            tauh_reg <= gvl_pkg::TAU_RST;
            tauv_reg <= gvl_pkg::TAU_RST;
            have_prev_reg <= 1'b0;
            have_filt_reg <= 1'b0;
            pq_reg <= 2'd0;
            pc_reg <= 16'd0;
            ptime_reg <= 63'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                px_reg[i] <= 32'd0;
                filt_reg[i] <= 32'd0;
            end
        end else begin
            if (wr_en) begin
                case (wr_idx)
                    gvl_pkg::REG_MAXH: maxh_reg <= pwdata[30:0];
                    gvl_pkg::REG_MAXV: maxv_reg <= pwdata[30:0];
                    gvl_pkg::REG_TAUH: tauh_reg <= pwdata[33:0];
                    gvl_pkg::REG_TAUV: tauv_reg <= pwdata[33:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                gvl_pkg::ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cx_reg[0] <= s_tdata[31:0];
                        cx_reg[1] <= s_tdata[63:32];
                        cx_reg[2] <= s_tdata[95:64];
                        ct_reg <= s_tdata[158:96];
                        cq_reg <= s_tdata[160:159];
                        cc_reg <= s_tdata[176:161];
                        state_reg <= gvl_pkg::ST_GATE;
                    end
                end
                gvl_pkg::ST_GATE: begin
                    dt_reg <= ct_reg - ptime_reg;
                    ok_reg <= cq_reg == gvl_pkg::QUALITY_GOOD && have_prev_reg
                        && pq_reg == gvl_pkg::QUALITY_GOOD && cc_reg == pc_reg
                        && ct_reg > ptime_reg
                        && (ct_reg - ptime_reg) >= gvl_pkg::DT_MIN_NS
                        && (ct_reg - ptime_reg) <= gvl_pkg::DT_MAX_NS;
                    axis_reg <= 2'd0;
                    lp_reg <= 1'b0;
                    state_reg <= (cq_reg == gvl_pkg::QUALITY_GOOD && have_prev_reg
                        && pq_reg == gvl_pkg::QUALITY_GOOD && cc_reg == pc_reg
                        && ct_reg > ptime_reg
                        && (ct_reg - ptime_reg) >= gvl_pkg::DT_MIN_NS
                        && (ct_reg - ptime_reg) <= gvl_pkg::DT_MAX_NS)
                        ? gvl_pkg::ST_MUL : gvl_pkg::ST_OUT;
                    cnt_reg <= 7'd0;
                    acc_reg <= 64'd0;
                    mcand_reg <= 64'd0;
                    mplier_reg <= 64'd0;
                end
                gvl_pkg::ST_MUL: begin
                    if (cnt_reg == 7'd0) begin
                        if (!lp_reg) begin
                            neg_reg <= diff[32];
                            mcand_reg <= {31'd0, (diff[32] ? (33'd0 - diff) : diff)};
                            mplier_reg <= gvl_pkg::NS_PER_S;
                        end else begin
                            neg_reg <= dfl[32];
                            mcand_reg <= {31'd0, (dfl[32] ? (33'd0 - dfl) : dfl)};
                            mplier_reg <= {1'b0, dt_reg};
                        end
                        acc_reg <= 64'd0;
                        cnt_reg <= 7'd1;
                    end else if (cnt_reg <= 7'd64) begin
                        if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                        mcand_reg <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[63:1]};
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        if (!lp_reg) begin
                            den_reg <= {1'b0, dt_reg};
                            quo_reg <= acc_reg + {2'b0, dt_reg[62:1]};
                        end else begin
                            den_reg <= {30'd0, tau_sel} + {1'b0, dt_reg};
                            quo_reg <= acc_reg + (({30'd0, tau_sel} + {1'b0, dt_reg}) >> 1);
                        end
                        rem_reg <= 64'd0;
                        cnt_reg <= 7'd0;
                        state_reg <= gvl_pkg::ST_DIV;
                    end
                end
                gvl_pkg::ST_DIV: begin
                    if (cnt_reg != 7'd64) begin
                        if (rem_sh >= den_reg) begin
                            rem_reg <= rem_sub;
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        cnt_reg <= 7'd0;
                        state_reg <= lp_reg ? gvl_pkg::ST_LPDIV : gvl_pkg::ST_CHECK;
                    end
                end
                gvl_pkg::ST_CHECK: begin
                    raw_reg[axis_reg] <= mag_sel;
                    if ({1'b0, qsat} > lim || (neg_reg && qsat == 32'h8000_0000))
                        ok_reg <= 1'b0;
                    if (axis_reg == 2'd2) begin
                        axis_reg <= 2'd0;
                        if (!(ok_reg && !({1'b0, qsat} > lim
                              || (neg_reg && qsat == 32'h8000_0000)))) begin
                            state_reg <= gvl_pkg::ST_OUT;
                        end else if (!have_filt_reg) begin
                            state_reg <= gvl_pkg::ST_OUT;
                        end else begin
                            lp_reg <= 1'b1;
                            state_reg <= gvl_pkg::ST_MUL;
                        end
                    end else begin
                        axis_reg <= axis_reg + 2'd1;
                        state_reg <= gvl_pkg::ST_MUL;
                    end
                end
                gvl_pkg::ST_LPDIV: begin
                    filt_reg[axis_reg] <= newf;
                    if (axis_reg == 2'd2) begin
                        state_reg <= gvl_pkg::ST_OUT;
                    end else begin
                        axis_reg <= axis_reg + 2'd1;
                        state_reg <= gvl_pkg::ST_MUL;
                    end
                end
                gvl_pkg::ST_OUT: begin
                    for (int i = 0; i < 3; i++) px_reg[i] <= cx_reg[i];
                    ptime_reg <= ct_reg;
                    pq_reg <= cq_reg;
                    pc_reg <= cc_reg;
                    have_prev_reg <= 1'b1;
                    out_valid_reg <= 1'b1;
                    out_user_reg <= ok_reg;
                    if (!ok_reg) begin
                        have_filt_reg <= 1'b0;
                        for (int i = 0; i < 3; i++) filt_reg[i] <= 32'd0;
                        out_data_reg <= 96'd0;
                    end else if (!lp_reg) begin
                        have_filt_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) filt_reg[i] <= raw_reg[i];
                        out_data_reg <= {raw_reg[2], raw_reg[1], raw_reg[0]};
                    end else begin
                        out_data_reg <= {filt_reg[2], filt_reg[1], filt_reg[0]};
                    end
                    state_reg <= gvl_pkg::ST_IDLE;
                end
                default: state_reg <= gvl_pkg::ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != gvl_pkg::ST_IDLE) |-> !s_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 96'd0))
        else $error("invalid word not zero");
endmodule
`default_nettype wire

// ===== sim/tb_gated_velocity_lowpass.sv =====
// Testbench for the gated velocity low-pass: directed and random pose streams against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_gated_velocity_lowpass;
    localparam logic [1:0] Q_LOST = 2'd0;
    localparam logic [1:0] Q_WEAK = 2'd1;
    localparam logic [1:0] Q_BAD = 2'd3;
    localparam int LATENCY = 800;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        valid;
    } vel_t;

    class velocity_scoreboard;
        longint unsigned maxh, maxv, tauh, tauv;
        longint px, py, pz;
        longint unsigned ptime;
        logic [1:0] pqual;
        logic [15:0] pcount;
        bit have_prev, have_filt;
        longint fx, fy, fz;
        vel_t pending_vel[$];
        int errors;

        function new();
            maxh = gvl_pkg::MAXH_RST;
            maxv = gvl_pkg::MAXV_RST;
            tauh = gvl_pkg::TAU_RST;
            tauv = gvl_pkg::TAU_RST;
            px = 0; py = 0; pz = 0; ptime = 0; pqual = Q_LOST; pcount = 0;
            have_prev = 0; have_filt = 0;
            fx = 0; fy = 0; fz = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, longint unsigned val);
            case (idx)
                gvl_pkg::REG_MAXH: maxh = val & 64'h7FFF_FFFF;
                gvl_pkg::REG_MAXV: maxv = val & 64'h7FFF_FFFF;
                gvl_pkg::REG_TAUH: tauh = val & 64'h3_FFFF_FFFF;
                gvl_pkg::REG_TAUV: tauv = val & 64'h3_FFFF_FFFF;
                default: ;
            endcase
        endfunction

        function longint speed(longint now, longint was, longint unsigned dt);
            longint d;
            longint unsigned mag, q;
            d = now - was;
            mag = (d < 0) ? longint'(-d) : d;
            q = (mag * gvl_pkg::NS_PER_S + dt / 2) / dt;
            if (d < 0) begin
                if (q > 64'h8000_0000) q = 64'h8000_0000;
                return -longint'(q);
            end
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            return longint'(q);
        endfunction

        function longint unsigned mag_of(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint smooth(longint f, longint r, longint unsigned dt,
                                longint unsigned tau);
            longint d;
            longint unsigned q;
            d = r - f;
            q = (mag_of(d) * dt + (tau + dt) / 2) / (tau + dt);
            return (d < 0) ? f - longint'(q) : f + longint'(q);
        endfunction

        function void note_sample(logic [183:0] w);
            longint x, y, z, rx, ry, rz;
            longint unsigned t, dt;
            logic [1:0] q;
            logic [15:0] c;
            bit ok;
            vel_t v;
            x = longint'($signed(w[31:0]));
            y = longint'($signed(w[63:32]));
            z = longint'($signed(w[95:64]));
            t = {1'b0, w[158:96]};
            q = w[160:159];
            c = w[176:161];
            ok = q == gvl_pkg::QUALITY_GOOD && have_prev && pqual == gvl_pkg::QUALITY_GOOD &&
                 c == pcount && t > ptime;
            dt = 0;
            rx = 0; ry = 0; rz = 0;
            if (ok) begin
                dt = t - ptime;
                ok = dt >= gvl_pkg::DT_MIN_NS && dt <= gvl_pkg::DT_MAX_NS;
            end
            if (ok) begin
                rx = speed(x, px, dt);
                ry = speed(y, py, dt);
                rz = speed(z, pz, dt);
                ok = mag_of(rx) <= maxh && mag_of(ry) <= maxh && mag_of(rz) <= maxv;
            end
            px = x; py = y; pz = z; ptime = t; pqual = q; pcount = c;
            have_prev = 1;
            if (!ok) begin
                have_filt = 0;
                fx = 0; fy = 0; fz = 0;
                v = '0;
            end else begin
                if (!have_filt) begin
                    fx = rx; fy = ry; fz = rz;
                    have_filt = 1;
                end else begin
                    fx = smooth(fx, rx, dt, tauh);
                    fy = smooth(fy, ry, dt, tauh);
                    fz = smooth(fz, rz, dt, tauv);
                end
                v.vx = fx[31:0];
                v.vy = fy[31:0];
                v.vz = fz[31:0];
                v.valid = 1'b1;
            end
            pending_vel.push_back(v);
        endfunction

        function void check_velocity(logic [95:0] d, logic u);
            vel_t e;
            if (pending_vel.size() == 0) begin
                errors++;
                $display("%0t: unexpected word vel=%h valid=%b", $time, d, u);
                return;
            end
            e = pending_vel.pop_front();
            if (d[31:0] !== e.vx) begin
                errors++;
                $display("%0t: vel_x expected %h actual %h", $time, e.vx, d[31:0]);
            end
            if (d[63:32] !== e.vy) begin
                errors++;
                $display("%0t: vel_y expected %h actual %h", $time, e.vy, d[63:32]);
            end
            if (d[95:64] !== e.vz) begin
                errors++;
                $display("%0t: vel_z expected %h actual %h", $time, e.vz, d[95:64]);
            end
            if (u !== e.valid) begin
                errors++;
                $display("%0t: vel_valid expected %b actual %b", $time, e.valid, u);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [183:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic m_tuser;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    velocity_scoreboard sb = new();
    bit no_idle = 0;
    int rx_hold = 0;
    longint cycles = 0;

    // track of the generated pose stream
    longint cur_x, cur_y, cur_z;
    longint unsigned cur_t;
    logic [15:0] cur_cnt;

    gated_velocity_lowpass i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int gap;
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    m_tready <= 0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_velocity(m_tdata, m_tuser);
        end
    end

    task automatic reg_write(logic [1:0] idx, longint unsigned val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_sample(longint x, longint y, longint z, longint unsigned t,
                               logic [1:0] q, logic [15:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {7'b0, c, q, t[62:0], z[31:0], y[31:0], x[31:0]};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(s_tdata);
        cur_x = longint'($signed(x[31:0]));
        cur_y = longint'($signed(y[31:0]));
        cur_z = longint'($signed(z[31:0]));
        cur_t = t & 64'h7FFF_FFFF_FFFF_FFFF;
        cur_cnt = c;
    endtask

    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 0;
        while (sb.pending_vel.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic longint step_pos(longint unsigned lim, bit over,
                                        longint unsigned dt);
        longint v;
        v = over ? longint'(lim) + 1 + $urandom_range(0, 5000)
                 : longint'($urandom_range(0, int'(lim[31:0])));
        if ($urandom_range(0, 1)) v = -v;
        return (v * longint'(dt)) / 1000000000;
    endfunction

    task automatic random_sample();
        int kind;
        longint unsigned dt, lh, lv;
        bit over;
        kind = $urandom_range(0, 99);
        lh = sb.maxh > 64'h7FFF_0000 ? 64'h7FFF_0000 : sb.maxh;
        lv = sb.maxv > 64'h7FFF_0000 ? 64'h7FFF_0000 : sb.maxv;
        if (kind < 78) begin
            dt = $urandom_range(5000000, 200000000);
            over = $urandom_range(0, 19) == 0;
            send_sample(cur_x + step_pos(lh, over, dt), cur_y + step_pos(lh, 0, dt),
                        cur_z + step_pos(lv, over && kind[0], dt), cur_t + dt,
                        gvl_pkg::QUALITY_GOOD, cur_cnt);
        end else begin
            case ($urandom_range(0, 5))
                0: send_sample(cur_x, cur_y, cur_z, cur_t + 10000000,
                               2'($urandom_range(0, 3)), cur_cnt);
                1: send_sample(cur_x, cur_y, cur_z, cur_t + 10000000,
                               gvl_pkg::QUALITY_GOOD, 16'($urandom));
                2: send_sample(cur_x, cur_y, cur_z,
                               cur_t + ($urandom_range(0, 1) ? $urandom_range(0, 4999999)
                                        : $urandom_range(200000001, 400000000)),
                               gvl_pkg::QUALITY_GOOD, cur_cnt);
                3: send_sample(cur_x, cur_y, cur_z, cur_t - $urandom_range(0, 1000),
                               gvl_pkg::QUALITY_GOOD, cur_cnt);
                4: send_sample($urandom, $urandom, $urandom,
                               {$urandom, $urandom}, 2'($urandom_range(0, 3)),
                               16'($urandom));
                default: send_sample($urandom, $urandom, $urandom,
                                     cur_t + $urandom_range(5000000, 200000000),
                                     gvl_pkg::QUALITY_GOOD, cur_cnt);
            endcase
        end
    endtask

    task automatic set_all(longint unsigned mh, longint unsigned mv,
                           longint unsigned th, longint unsigned tv);
        reg_write(gvl_pkg::REG_MAXH, mh);
        reg_write(gvl_pkg::REG_MAXV, mv);
        reg_write(gvl_pkg::REG_TAUH, th);
        reg_write(gvl_pkg::REG_TAUV, tv);
    endtask

    initial begin
        longint unsigned t0;
        cur_x = 0; cur_y = 0; cur_z = 0; cur_t = 0; cur_cnt = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        repeat (2) @(posedge aclk);

        // directed: gates, bounds, seeding and saturation
        t0 = 64'd1000000000;
        send_sample(0, 0, 0, t0, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(0, 0, 0, t0 + 5000000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(65536, -65536, 32768, t0 + 205000000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(65536, -65536, 32768, t0 + 210000000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(65536, -65536, 32768, t0 + 410000001, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(65536, -65536, 32768, t0 + 414999999, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(70000, -60000, 30000, t0 + 424999999, Q_WEAK, 0);
        send_sample(70000, -60000, 30000, t0 + 434999999, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(70000, -60000, 30000, t0 + 444999999, Q_BAD, 0);
        send_sample(70000, -60000, 30000, t0 + 454999999, Q_LOST, 0);
        send_sample(70000, -60000, 30000, t0 + 464999999, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(70000, -60000, 30000, t0 + 474999999, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(70000, -60000, 30000, t0 + 474999999, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(70000, -60000, 30000, t0 + 474000000, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(70000, -60000, 30000, t0 + 484000000, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(2000000, -60000, 30000, t0 + 494000000, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(2000000, -60000, 30000, t0 + 504000000, gvl_pkg::QUALITY_GOOD, 16'hFFFF);
        send_sample(2000000, -60000, 900000, t0 + 514000000, gvl_pkg::QUALITY_GOOD,
                    16'hFFFF);
        drain();

        set_all(64'h7FFF_FFFF, 64'h7FFF_FFFF, 1, 1);
        send_sample(-64'sd2147483648, -64'sd2147483648, 2147483647,
                    64'h7FFF_FFFF_F000_0000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(-64'sd2147483648, -64'sd2147483648, 2147483647,
                    64'h7FFF_FFFF_F04C_4B40, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(2147483647, -64'sd2147483648, 2147483647,
                    64'h7FFF_FFFF_F098_9680, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(2147483647, 2147483647, -64'sd2147483648,
                    64'h7FFF_FFFF_F0E4_E1C0, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(0, 0, 0, 64'd5000000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(1000, 1000, -1000, 64'd10000000, gvl_pkg::QUALITY_GOOD, 0);
        send_sample(2000, 3000, -1000, 64'd15000000, gvl_pkg::QUALITY_GOOD, 0);
        drain();

        // random phases across register settings, extremes among them
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_all(gvl_pkg::MAXH_RST, gvl_pkg::MAXV_RST, gvl_pkg::TAU_RST,
                           gvl_pkg::TAU_RST);
                1: set_all(0, 0, 64'd10000000000, 64'd10000000000);
                2: set_all(64'h7FFF_FFFF, 64'h7FFF_FFFF, 0, 0);
                3: set_all(64'hFFFF_FFFF, 64'h0000_FFFF, 64'h3_FFFF_FFFF, 1);
                4: set_all(64'd2000000, 64'd1000000, 64'd50000000, 64'd5000000000);
                5: set_all($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
                default: set_all(64'h7FFF_FFFF, gvl_pkg::MAXV_RST, 64'h4_0000_0001, 64'd7);
            endcase
            no_idle = (ph == 3);
            for (int i = 0; i < 140; i++) random_sample();
            if (ph == 4) begin
                rx_hold = 5000;
                for (int i = 0; i < 12; i++) random_sample();
            end
            drain();
        end

        no_idle = 0;
        while (sb.pending_vel.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
